// ----- sv/swm_pkg.sv -----
// ----------------------------------------------------------------------------
// swm_pkg
// Shared constants and types for the sliding window median filter.
// ----------------------------------------------------------------------------
package swm_pkg;

   // Window geometry and sample format
   localparam int WINDOW_LENGTH = 5;    // 1 .. 31
   localparam int SAMPLE_WIDTH  = 16;   // 2 .. 32

   // Slot index width (at least one bit)
   localparam int IDX_W = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
   // Count width, holds 0 .. WINDOW_LENGTH
   localparam int CNT_W = $clog2(WINDOW_LENGTH + 1);

   // Rank selected from the sorted window (upper median for even lengths)
   localparam logic [CNT_W-1:0] MEDIAN_RANK = CNT_W'(WINDOW_LENGTH / 2);
   localparam logic [IDX_W-1:0] LAST_SLOT   = IDX_W'(WINDOW_LENGTH - 1);

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RANK,
      ST_OUT
   } median_state_type;

endpackage

// ----- sv/sliding_window_median_top.sv -----
// ----------------------------------------------------------------------------
// sliding_window_median_top
// Running median filter over a circular window of signed samples.
// ----------------------------------------------------------------------------
// Each item on the req_ channel carries one signed sample. The sample
// overwrites the oldest slot of a WINDOW_LENGTH-deep window, then the block
// returns on the rsp_ channel the window entry of rank WINDOW_LENGTH/2
// (counted from zero, ascending; for an even length that is the upper
// median). The window starts out all zero after reset, so the first results
// rank the new samples together with those zeros. One item at a time: the
// sample is written in the accept cycle, then a rank unit checks one
// candidate slot per cycle against the whole window, stopping at the first
// slot whose rank range covers the median rank. An item therefore passes
// the accept, rank and output states in that order, and stays in the
// output state while rsp_ready is held low. req_ready is high only while
// the block is idle.
// ----------------------------------------------------------------------------
module sliding_window_median_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [swm_pkg::SAMPLE_WIDTH-1:0] req_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [swm_pkg::SAMPLE_WIDTH-1:0] rsp_median_value
);
   import swm_pkg::*;

   // Control state
   median_state_type state_ff, state_in;
   logic [IDX_W-1:0] wpos_ff,  wpos_in;   // next slot to overwrite
   logic [IDX_W-1:0] cand_ff,  cand_in;   // candidate slot under test

   // Window and result
   sample_type window_ff [WINDOW_LENGTH];
   sample_type window_in [WINDOW_LENGTH];
   sample_type median_ff, median_in;

   // Rank unit signals
   sample_type       cand_value;
   logic [CNT_W-1:0] below_cnt;
   logic [CNT_W-1:0] upto_cnt;
   logic             cand_hit;

   logic req_accept;
   logic rsp_accept;

   assign req_accept = req_valid & req_ready;
   assign rsp_accept = rsp_valid & rsp_ready;

   // ------------------------------------------------------------------------
   // Rank unit: counts window entries strictly below and at-or-below the
   // candidate. The candidate holds the median if its rank interval
   // [below, upto) contains MEDIAN_RANK. Ties are handled by that interval.
   // ------------------------------------------------------------------------
   assign cand_value = window_ff[cand_ff];

   always_comb begin
      below_cnt = '0;
      upto_cnt  = '0;
      for (int j = 0; j < WINDOW_LENGTH; j++) begin
         below_cnt = below_cnt + CNT_W'(window_ff[j] <  cand_value);
         upto_cnt  = upto_cnt  + CNT_W'(window_ff[j] <= cand_value);
      end
      cand_hit = (below_cnt <= MEDIAN_RANK) && (MEDIAN_RANK < upto_cnt);
   end

   // ------------------------------------------------------------------------
   // Sequencer: next state
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) state_in = ST_RANK;
         end
         ST_RANK: begin
            // some slot always hits; the last one is a safe stop
            if (cand_hit || (cand_ff == LAST_SLOT)) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_accept) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------------
   // Sequencer: outputs and datapath next values
   // ------------------------------------------------------------------------
   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cand_in   = cand_ff;
      median_in = median_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cand_in   = '0;
         end
         ST_RANK: begin
            if (cand_hit) median_in = cand_value;
            cand_in = cand_ff + IDX_W'(1);
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
         end
         default: begin
            cand_in = '0;
         end
      endcase
   end

   // Window write and write pointer wrap
   always_comb begin
      for (int e = 0; e < WINDOW_LENGTH; e++) begin
         window_in[e] = (req_accept && (wpos_ff == IDX_W'(e))) ? req_sample
                                                               : window_ff[e];
      end
      wpos_in = wpos_ff;
      if (req_accept) begin
         wpos_in = (wpos_ff == LAST_SLOT) ? '0 : wpos_ff + IDX_W'(1);
      end
   end

   assign rsp_median_value = median_ff;

   // ------------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wpos_ff  <= '0;
         cand_ff  <= '0;
         for (int e = 0; e < WINDOW_LENGTH; e++) begin
            window_ff[e] <= '0;
         end
      end else begin
         state_ff <= state_in;
         wpos_ff  <= wpos_in;
         cand_ff  <= cand_in;
         for (int e = 0; e < WINDOW_LENGTH; e++) begin
            window_ff[e] <= window_in[e];
         end
      end
   end

   always_ff @(posedge clock) begin
      median_ff <= median_in;
   end

endmodule
